// ===== sv/lsw_pkg.sv =====
package lsw_pkg;

  typedef logic [2:0] func_t;

  localparam func_t FN_TICK      = 3'd0;
  localparam func_t FN_LAP       = 3'd1;
  localparam func_t FN_STOP      = 3'd2;
  localparam func_t FN_CLR_CUR   = 3'd3;
  localparam func_t FN_CLR_LAPS  = 3'd4;
  localparam func_t FN_CLR_BOTH  = 3'd5;
  localparam func_t FN_READ      = 3'd6;

  localparam logic [15:0] WARN_RESET = 16'd5000;

  // reciprocal constants for the time split, exact over the value ranges used
  localparam logic [28:0] DIV1000_M  = 29'd274877907;
  localparam int          DIV1000_SH = 38;
  localparam logic [22:0] DIV60_M    = 23'd4473925;
  localparam int          DIV60_SH   = 28;
  localparam logic [11:0] DIV24_M    = 12'd2731;
  localparam int          DIV24_SH   = 16;

  localparam logic [31:0] MS_PER_SEC    = 32'd1000;
  localparam logic [22:0] SEC_PER_MIN   = 23'd60;
  localparam logic [16:0] MIN_PER_HOUR  = 17'd60;
  localparam logic [10:0] HOURS_PER_DAY = 11'd24;

  typedef struct packed {
    logic        run;
    logic        warn;
    logic [31:0] lap_value;
    logic [4:0]  next_slot;
    logic        saved;
  } lsw_stat_t;

endpackage

// ===== sv/lsw_in_if.sv =====
interface lsw_in_if;
  import lsw_pkg::*;

  logic        valid;
  logic        ready;
  func_t       func;
  logic [31:0] now_ms;
  logic [4:0]  lap_slot;

  modport source (output valid, func, now_ms, lap_slot, input ready);
  modport sink (input valid, func, now_ms, lap_slot, output ready);
endinterface

// ===== sv/lsw_out_if.sv =====
interface lsw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_ms;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [9:0]  millis_part;
  logic        is_running;
  logic        warning;
  logic [31:0] lap_value;
  logic [4:0]  next_slot;
  logic        lap_saved;

  modport source (
    output valid, elapsed_ms, hours, minutes, seconds, millis_part,
           is_running, warning, lap_value, next_slot, lap_saved,
    input  ready
  );
  modport sink (
    input  valid, elapsed_ms, hours, minutes, seconds, millis_part,
           is_running, warning, lap_value, next_slot, lap_saved,
    output ready
  );
endinterface

// ===== sv/lsw_split.sv =====
module lsw_split (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_elapsed,
  input  lsw_pkg::lsw_stat_t in_stat,
  lsw_out_if.source          out_ch
);
  import lsw_pkg::*;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: seconds
  logic [31:0] e1_r, e2_r, e3_r, e4_r;
  logic [22:0] secs1_r, secs2_r;
  lsw_stat_t   st1_r, st2_r, st3_r, st4_r;
  logic [60:0] p1;

  // stage 2: millis and minutes
  logic [9:0]  ms2_r, ms3_r, ms4_r;
  logic [16:0] mins2_r, mins3_r;
  logic [44:0] p2;

  // stage 3: seconds part and hours
  logic [5:0]  sec3_r, sec4_r;
  logic [10:0] hrs3_r;
  logic [39:0] p3;

  // stage 4: minutes part and hours mod 24
  logic [5:0]  min4_r;
  logic [4:0]  hr4_r;
  logic [22:0] p4;
  logic [5:0]  q24;

  assign en4      = !v4_r || out_ch.ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign p1  = 61'(in_elapsed) * 61'(DIV1000_M);
  assign p2  = 45'(secs1_r) * 45'(DIV60_M);
  assign p3  = 40'(mins2_r) * 40'(DIV60_M);
  assign p4  = 23'(hrs3_r) * 23'(DIV24_M);
  assign q24 = p4[DIV24_SH+5:DIV24_SH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      e1_r    <= in_elapsed;
      secs1_r <= p1[DIV1000_SH+22:DIV1000_SH];
      st1_r   <= in_stat;
    end
    if (en2) begin
      e2_r    <= e1_r;
      secs2_r <= secs1_r;
      ms2_r   <= 10'(e1_r - 32'(secs1_r) * MS_PER_SEC);
      mins2_r <= p2[DIV60_SH+16:DIV60_SH];
      st2_r   <= st1_r;
    end
    if (en3) begin
      e3_r    <= e2_r;
      ms3_r   <= ms2_r;
      mins3_r <= mins2_r;
      sec3_r  <= 6'(secs2_r - 23'(mins2_r) * SEC_PER_MIN);
      hrs3_r  <= p3[DIV60_SH+10:DIV60_SH];
      st3_r   <= st2_r;
    end
    if (en4) begin
      e4_r   <= e3_r;
      ms4_r  <= ms3_r;
      sec4_r <= sec3_r;
      min4_r <= 6'(mins3_r - 17'(hrs3_r) * MIN_PER_HOUR);
      hr4_r  <= 5'(hrs3_r - 11'(q24) * HOURS_PER_DAY);
      st4_r  <= st3_r;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.elapsed_ms  = e4_r;
  assign out_ch.hours       = hr4_r;
  assign out_ch.minutes     = min4_r;
  assign out_ch.seconds     = sec4_r;
  assign out_ch.millis_part = ms4_r;
  assign out_ch.is_running  = st4_r.run;
  assign out_ch.warning     = st4_r.warn;
  assign out_ch.lap_value   = st4_r.lap_value;
  assign out_ch.next_slot   = st4_r.next_slot;
  assign out_ch.lap_saved   = st4_r.saved;

  // a stalled result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_ch.ready) |=> (v4_r && $stable(e4_r) && $stable(st4_r)))
    else $error("result word changed while stalled");

  // a word taken from stage 3 always lands in the output stage
  a_s3_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4) |=> v4_r)
    else $error("word lost between stage 3 and output");

  // minutes part stays below an hour
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (min4_r < 6'd60))
    else $error("minutes part out of range");

endmodule

// ===== sv/lap_stopwatch_top.sv =====
// channel   dir   handshake        word
// in_ch     in    valid / ready    func, now_ms, lap_slot
// out_ch    out   valid / ready    elapsed_ms, time split, status, lap data
// cfg       in    cfg_we           cfg_wdata = warn_duration_ms
//
// one word accepted per cycle while the pipe is not full, one result word per input word
// pipeline: input stage with lap ring read, state update stage,
//   then four stages of the time split (one reciprocal multiply each)
// rst_n synchronous: stopped, times zero, lap ring valid bits all cleared
// a stall at out_ch fills the pipe stage by stage; in_ch stays ready
//   while any stage is free
module lap_stopwatch_top #(
  parameter int LAP_SLOTS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  lsw_in_if.sink      in_ch,
  lsw_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import lsw_pkg::*;

  localparam int AW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam int XW = (AW > 5) ? AW : 5;
  localparam logic [AW:0] SLOTS_W = (AW + 1)'(LAP_SLOTS);
  localparam logic [XW:0] SLOTS_X = (XW + 1)'(LAP_SLOTS);

  // configuration
  logic [15:0] warn_dur_r;

  // architectural state
  logic          run_r, run_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [AW-1:0] wslot_r, wslot_nxt;
  logic          warn_act_r, warn_act_nxt;
  logic [31:0]   warn_start_r, warn_start_nxt;
  logic [LAP_SLOTS-1:0] lap_vld_r;

  // lap ring storage, valid bits above say which entries hold a lap
  logic [31:0] lap_mem [LAP_SLOTS];

  // input stage
  logic          a_v_r;
  func_t         a_func_r;
  logic [31:0]   a_now_r;
  logic [XW-1:0] a_slot_r;
  logic [31:0]   a_rd_r;
  logic          a_fwd_r;
  logic [31:0]   a_fwd_data_r;

  // update stage output register
  logic        b_v_r;
  logic [31:0] b_elapsed_r;
  lsw_stat_t   b_stat_r;

  logic split_ready;
  logic b_en, a_en, a_go, in_go;

  logic [XW-1:0] in_slot_x;
  logic [AW-1:0] in_addr, a_addr;
  logic          in_inrange, a_inrange;

  // update logic
  logic          warn_live;
  logic          lap_wr, clr_laps, wrap;
  logic [31:0]   lap_time, lap_val, elapsed;
  logic [AW:0]   ws_inc;

  // ---- handshake chain ----
  assign b_en        = !b_v_r || split_ready;
  assign a_en        = !a_v_r || b_en;
  assign a_go        = a_v_r && b_en;
  assign in_ch.ready = a_en;
  assign in_go       = in_ch.valid && a_en;

  // ---- lap ring read address ----
  assign in_slot_x  = XW'(in_ch.lap_slot);
  assign in_addr    = in_slot_x[AW-1:0];
  assign in_inrange = {1'b0, in_slot_x} < SLOTS_X;
  assign a_addr     = a_slot_r[AW-1:0];
  assign a_inrange  = {1'b0, a_slot_r} < SLOTS_X;

  // ---- state update for the word in the input stage ----
  assign lap_time = a_now_r + off_r - start_r;
  assign ws_inc   = {1'b0, wslot_r} + (AW + 1)'(1);

  always_comb begin
    // warning expires before the command acts
    warn_live      = warn_act_r && !((a_now_r - warn_start_r) > {16'd0, warn_dur_r});
    run_nxt        = run_r;
    start_nxt      = start_r;
    off_nxt        = off_r;
    wslot_nxt      = wslot_r;
    warn_act_nxt   = warn_live;
    warn_start_nxt = warn_start_r;
    lap_wr         = 1'b0;
    clr_laps       = 1'b0;
    wrap           = 1'b0;
    lap_val        = 32'd0;

    case (a_func_r)
      FN_LAP: begin
        if (!run_r) begin
          // start: offset is kept, no lap stored
          run_nxt   = 1'b1;
          start_nxt = a_now_r;
        end else begin
          lap_wr  = 1'b1;
          lap_val = lap_time;
          if (ws_inc == SLOTS_W) begin
            // ring wrapped: raise the warning, also for a zero timestamp
            wrap           = 1'b1;
            wslot_nxt      = '0;
            warn_act_nxt   = 1'b1;
            warn_start_nxt = a_now_r;
          end else begin
            wslot_nxt = ws_inc[AW-1:0];
          end
        end
      end
      FN_STOP: begin
        if (run_r) begin
          run_nxt = 1'b0;
          off_nxt = off_r + (a_now_r - start_r);
        end
      end
      FN_CLR_CUR: begin
        if (!run_r) begin
          start_nxt = 32'd0;
          off_nxt   = 32'd0;
        end
      end
      FN_CLR_LAPS: begin
        if (!run_r) begin
          clr_laps  = 1'b1;
          wslot_nxt = '0;
        end
      end
      FN_CLR_BOTH: begin
        if (!run_r) begin
          start_nxt = 32'd0;
          off_nxt   = 32'd0;
          clr_laps  = 1'b1;
          wslot_nxt = '0;
        end
      end
      FN_READ: begin
        // never-written or cleared entries read as empty; a write by the
        // word just ahead landed after the ring read, so take it forwarded
        if (a_inrange && lap_vld_r[a_addr]) begin
          lap_val = a_fwd_r ? a_fwd_data_r : a_rd_r;
        end
      end
      default: begin
        // tick and the unused code only refresh the readout
      end
    endcase

    elapsed = run_nxt ? (a_now_r + off_nxt - start_nxt) : off_nxt;
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_dur_r <= WARN_RESET;
    end else if (cfg_we) begin
      warn_dur_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      start_r      <= 32'd0;
      off_r        <= 32'd0;
      wslot_r      <= '0;
      warn_act_r   <= 1'b0;
      warn_start_r <= 32'd0;
      lap_vld_r    <= '0;
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
    end else begin
      if (a_en) a_v_r <= in_ch.valid;
      if (b_en) b_v_r <= a_v_r;
      if (a_go) begin
        run_r        <= run_nxt;
        start_r      <= start_nxt;
        off_r        <= off_nxt;
        wslot_r      <= wslot_nxt;
        warn_act_r   <= warn_act_nxt;
        warn_start_r <= warn_start_nxt;
        if (clr_laps) begin
          lap_vld_r <= '0;
        end else if (lap_wr) begin
          lap_vld_r[wslot_r] <= 1'b1;
        end
      end
    end
  end

  // lap ring write and registered read
  always_ff @(posedge clk) begin
    if (a_go && lap_wr) begin
      lap_mem[wslot_r] <= lap_time;
    end
    if (in_go && in_inrange) begin
      a_rd_r <= lap_mem[in_addr];
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_func_r     <= in_ch.func;
      a_now_r      <= in_ch.now_ms;
      a_slot_r     <= in_slot_x;
      a_fwd_r      <= a_go && lap_wr && (wslot_r == in_addr);
      a_fwd_data_r <= lap_time;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (b_en) begin
      b_elapsed_r         <= elapsed;
      b_stat_r.run        <= run_nxt;
      b_stat_r.warn       <= warn_act_nxt;
      b_stat_r.lap_value  <= lap_val;
      b_stat_r.next_slot  <= 5'(wslot_nxt);
      b_stat_r.saved      <= lap_wr;
    end
  end

  // ---- time split pipeline and result register ----
  lsw_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (b_v_r),
    .in_ready   (split_ready),
    .in_elapsed (b_elapsed_r),
    .in_stat    (b_stat_r),
    .out_ch     (out_ch)
  );

  // ---- assertions ----
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wslot_r} < SLOTS_W))
    else $error("write slot beyond ring");

  a_wrap_warn: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && wrap) |=> (warn_act_r && (wslot_r == '0)))
    else $error("ring wrap did not raise warning");

  a_stopped_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && !run_nxt) |=> (b_elapsed_r == off_r))
    else $error("stopped readout differs from offset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> in_ch.ready)
    else $error("input refused with empty input stage");

  a_saved_running: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && lap_wr) |=> (run_r && b_stat_r.saved))
    else $error("lap stored while stopped");

endmodule

// ===== test/lsw_checker.sv =====
`timescale 1ns / 100ps

module lsw_checker #(
  parameter int LAP_SLOTS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  lsw_in_if           in_ch,
  lsw_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending_words
);
  import lsw_pkg::*;

  localparam logic [31:0] MS_IN_SEC    = 32'd1000;
  localparam logic [31:0] SEC_IN_MIN   = 32'd60;
  localparam logic [31:0] MIN_IN_HOUR  = 32'd60;
  localparam logic [31:0] HOURS_IN_DAY = 32'd24;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis_part;
    logic        is_running;
    logic        warning;
    logic [31:0] lap_value;
    logic [4:0]  next_slot;
    logic        lap_saved;
  } watch_word_t;

  // stopwatch shadow state
  logic [15:0]  warn_limit;
  logic         running;
  logic [31:0]  started_at;
  logic [31:0]  banked_ms;
  logic [31:0]  lap_store [LAP_SLOTS];
  int unsigned  wr_slot;
  logic         warn_on;
  logic [31:0]  warn_t0;

  watch_word_t  expected_words [$];

  function automatic void reset_watch();
    warn_limit = WARN_RESET;
    running    = 1'b0;
    started_at = '0;
    banked_ms  = '0;
    foreach (lap_store[i]) lap_store[i] = '0;
    wr_slot    = 0;
    warn_on    = 1'b0;
    warn_t0    = '0;
  endfunction

  function automatic void wipe_laps();
    foreach (lap_store[i]) lap_store[i] = '0;
    wr_slot = 0;
  endfunction

  task automatic step_watch(input func_t f, input logic [31:0] now, input logic [4:0] slot,
                            output watch_word_t w);
    logic [31:0] elapsed;
    logic [31:0] secs;
    logic [31:0] mins;
    logic [31:0] hrs;
    logic [31:0] lap_val;
    logic        saved;
    lap_val = '0;
    saved   = 1'b0;
    if (warn_on && ((now - warn_t0) > {16'd0, warn_limit}))
      warn_on = 1'b0;
    case (f)
      FN_LAP: begin
        if (!running) begin
          running    = 1'b1;
          started_at = now;
        end else begin
          lap_val = now + banked_ms - started_at;
          if (wr_slot >= LAP_SLOTS) wr_slot = 0;
          lap_store[wr_slot] = lap_val;
          saved = 1'b1;
          wr_slot++;
          if (wr_slot >= LAP_SLOTS) begin
            wr_slot = 0;
            warn_on = 1'b1;
            warn_t0 = now;
          end
        end
      end
      FN_STOP: begin
        if (running) begin
          running   = 1'b0;
          banked_ms = banked_ms + (now - started_at);
        end
      end
      FN_CLR_CUR: begin
        if (!running) begin
          started_at = '0;
          banked_ms  = '0;
        end
      end
      FN_CLR_LAPS: begin
        if (!running) wipe_laps();
      end
      FN_CLR_BOTH: begin
        if (!running) begin
          started_at = '0;
          banked_ms  = '0;
          wipe_laps();
        end
      end
      FN_READ: begin
        if (slot < LAP_SLOTS) lap_val = lap_store[slot];
      end
      default: ;
    endcase
    elapsed = running ? (now + banked_ms - started_at) : banked_ms;
    secs = elapsed / MS_IN_SEC;
    mins = secs / SEC_IN_MIN;
    hrs  = mins / MIN_IN_HOUR;
    w.elapsed_ms  = elapsed;
    w.hours       = 5'(hrs % HOURS_IN_DAY);
    w.minutes     = 6'(mins % MIN_IN_HOUR);
    w.seconds     = 6'(secs % SEC_IN_MIN);
    w.millis_part = 10'(elapsed % MS_IN_SEC);
    w.is_running  = running;
    w.warning     = warn_on;
    w.lap_value   = lap_val;
    w.next_slot   = 5'(wr_slot);
    w.lap_saved   = saved;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    watch_word_t want;
    watch_word_t got;
    if (!rst_n) begin
      reset_watch();
      expected_words.delete();
    end else begin
      if (cfg_we) warn_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        step_watch(in_ch.func, in_ch.now_ms, in_ch.lap_slot, want);
        expected_words.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.elapsed_ms  = out_ch.elapsed_ms;
        got.hours       = out_ch.hours;
        got.minutes     = out_ch.minutes;
        got.seconds     = out_ch.seconds;
        got.millis_part = out_ch.millis_part;
        got.is_running  = out_ch.is_running;
        got.warning     = out_ch.warning;
        got.lap_value   = out_ch.lap_value;
        got.next_slot   = out_ch.next_slot;
        got.lap_saved   = out_ch.lap_saved;
        if (expected_words.size() == 0) begin
          $display("%0t: result word expected none actual elapsed_ms %0d",
                   $time, got.elapsed_ms);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
          check_field("hours", want.hours, got.hours);
          check_field("minutes", want.minutes, got.minutes);
          check_field("seconds", want.seconds, got.seconds);
          check_field("millis_part", want.millis_part, got.millis_part);
          check_field("is_running", want.is_running, got.is_running);
          check_field("warning", want.warning, got.warning);
          check_field("lap_value", want.lap_value, got.lap_value);
          check_field("next_slot", want.next_slot, got.next_slot);
          check_field("lap_saved", want.lap_saved, got.lap_saved);
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lsw_pkg::*;

  localparam int LAP_SLOTS    = 30;
  localparam int RANDOM_WORDS = 1450;
  localparam int N_PHASES     = 6;
  // leave some margin after the last result word before touching the register
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  // command code 7 is unused by the block and behaves as a tick
  localparam func_t FN_SPARE  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  lsw_in_if  in_ch();
  lsw_out_if out_ch();

  int          fail_count;
  int          pending_words;
  int          sent_words;
  int          cycle_count;
  bit          no_idle;
  logic [31:0] clock_ms;

  lap_stopwatch_top #(.LAP_SLOTS(LAP_SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lsw_checker #(.LAP_SLOTS(LAP_SLOTS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure, ready held low with a 13 percent chance unless no_idle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 13);
    end
  end

  // offer one word and hold it until the block takes it
  // valid only drops during a gap, so back-to-back words keep it high
  task automatic send_word(input func_t f, input logic [31:0] now, input logic [4:0] slot);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.now_ms   <= now;
    in_ch.lap_slot <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  // sender holds off until every result word is back, then lets the pipe settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes only happen on an empty pipe
  task automatic write_warn(input logic [15:0] limit);
    wait_drained();
    cfg_wdata <= limit;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly small forward steps, sometimes long pauses, jumps and wraps of the timestamp
  task automatic bump_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      ;
    else if (r < 75)
      clock_ms += $urandom_range(1, 2000);
    else if (r < 92)
      clock_ms += $urandom_range(2000, 70000);
    else if (r < 97)
      clock_ms += $urandom();
    else
      clock_ms = $urandom();
  endtask

  function automatic logic [4:0] pick_slot();
    if ($urandom_range(0, 99) < 85)
      return 5'($urandom_range(0, LAP_SLOTS - 1));
    else
      return 5'($urandom_range(LAP_SLOTS, 31));
  endfunction

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14)      return FN_TICK;
    else if (r < 46) return FN_LAP;
    else if (r < 56) return FN_STOP;
    else if (r < 64) return FN_CLR_CUR;
    else if (r < 70) return FN_CLR_LAPS;
    else if (r < 76) return FN_CLR_BOTH;
    else if (r < 94) return FN_READ;
    else             return FN_SPARE;
  endfunction

  // one word at the running timestamp, then let time move on
  task automatic send_timed(input func_t f);
    send_word(f, clock_ms, pick_slot());
    bump_clock();
  endtask

  // well-formed run: stop, optional clear, start, a string of laps, maybe stop and read back
  // a fresh ring wraps on every 30th lap, sometimes at a zero timestamp
  task automatic lap_session();
    int  n_laps;
    bit  fresh;
    int  i;
    n_laps = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 62) : $urandom_range(1, 12);
    fresh  = $urandom_range(0, 1);
    send_timed(FN_STOP);
    if (fresh)
      send_timed(FN_CLR_BOTH);
    else if ($urandom_range(0, 1))
      send_timed(FN_CLR_CUR);
    send_timed(FN_LAP);
    for (i = 1; i <= n_laps; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_timed($urandom_range(0, 1) ? FN_READ : FN_TICK);
      if (fresh && (i % LAP_SLOTS == 0) && $urandom_range(0, 1))
        clock_ms = '0;
      send_timed(FN_LAP);
    end
    if ($urandom_range(0, 2) != 0) begin
      send_timed(FN_STOP);
      repeat ($urandom_range(0, 3)) send_timed(FN_READ);
    end
  endtask

  function automatic logic [15:0] phase_limit(input int ph);
    case (ph)
      0:       return WARN_RESET;
      1:       return 16'h0000;
      2:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int  ph;
    int  target;
    bit  paused;
    // every block input known from time zero
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_TICK;
    in_ch.now_ms   <= '0;
    in_ch.lap_slot <= '0;
    no_idle        = 1'b0;
    clock_ms       = '0;
    paused         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_warn(WARN_RESET);

    // directed words: empty ring, timestamp extremes, commands in both run states
    send_word(FN_TICK,     32'h0000_0000, 5'd0);
    send_word(FN_STOP,     32'hFFFF_FFFF, 5'd31);   // stop while stopped
    send_word(FN_CLR_CUR,  32'h0000_0010, 5'd0);
    send_word(FN_CLR_LAPS, 32'h0000_0020, 5'd0);
    send_word(FN_CLR_BOTH, 32'h0000_0030, 5'd0);
    send_word(FN_READ,     32'h0000_0040, 5'd0);    // slot never written
    send_word(FN_READ,     32'h0000_0050, 5'd29);
    send_word(FN_READ,     32'h0000_0060, 5'd30);   // past the ring
    send_word(FN_READ,     32'h0000_0070, 5'd31);
    send_word(FN_SPARE,    32'hFFFF_FFFF, 5'd31);   // unused code
    send_word(FN_LAP,      32'hFFFF_FF00, 5'd0);    // start while stopped
    send_word(FN_LAP,      32'h0000_0100, 5'd0);    // lap across the timestamp wrap
    send_word(FN_CLR_CUR,  32'h0000_0200, 5'd0);    // clears ignored while running
    send_word(FN_CLR_LAPS, 32'h0000_0300, 5'd0);
    send_word(FN_CLR_BOTH, 32'h0000_0400, 5'd0);
    send_word(FN_READ,     32'h0000_0500, 5'd0);
    send_word(FN_LAP,      32'h8000_0000, 5'd0);
    send_word(FN_STOP,     32'hF000_0000, 5'd0);    // large offset, hours wrap
    send_word(FN_LAP,      32'h0000_0005, 5'd1);    // restart keeps the offset
    send_word(FN_STOP,     32'h0000_0005, 5'd1);    // zero-length run
    send_word(FN_TICK,     32'hFFFF_FFFF, 5'd1);
    send_word(FN_READ,     32'hFFFF_FFFF, 5'd1);
    send_word(FN_CLR_CUR,  32'h0000_0000, 5'd0);
    send_word(FN_READ,     32'h0000_0000, 5'd0);

    // random phases, each under its own warning duration
    for (ph = 0; ph < N_PHASES; ph++) begin
      write_warn(phase_limit(ph));
      no_idle = (ph == 3);   // one long stretch with both sides always willing
      target  = sent_words + RANDOM_WORDS / N_PHASES;
      while (sent_words < target) begin
        if (ph == 1 && !paused && sent_words >= target - 120) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7)
          lap_session();
        else
          repeat ($urandom_range(4, 16)) send_word(pick_func(), clock_ms, pick_slot());
        bump_clock();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    if (fail_count == 0 && pending_words == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
